@@ rtl/skf_pkg.sv @@
// Shared widths, constants, microcode formats and control store for the scalar Kalman filter.
package skf_pkg;

  localparam int unsigned EstW     = 32;
  localparam int unsigned CovW     = 31;
  localparam int unsigned GainW    = 17;
  localparam int unsigned GainBits = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DivW     = CovW + 1;
  localparam int unsigned NumW     = CovW + GainBits + 1;
  localparam int unsigned MulW     = (GainW + 1) + (EstW + 1);
  localparam int unsigned CntW     = 5;
  localparam int unsigned StepW    = 4;

  localparam logic [EstW-1:0]  InitEstReset   = 32'd3276800;
  localparam logic [CovW-1:0]  InitCovReset   = 31'd65536;
  localparam logic [CovW-1:0]  ProcNoiseReset = 31'd3277;
  localparam logic [CovW-1:0]  CovMax         = '1;
  localparam logic [GainW-1:0] GainOne        = 17'h10000;
  localparam logic [CntW-1:0]  DivLastBit     = 5'd16;
  localparam logic signed [MulW-1:0] RoundHalf = 51'sd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_EST,
    CFG_INIT_COV,
    CFG_PROC_NOISE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LATCH,
    UOP_PRED,
    UOP_SUM,
    UOP_NUM,
    UOP_DIV,
    UOP_ERR,
    UOP_MULE,
    UOP_UPDX,
    UOP_MULP,
    UOP_UPDP,
    UOP_RST,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_ZERO,
    COND_LOOP,
    COND_ACCEPT,
    COND_EMIT
  } cond_e;

  typedef logic [StepW-1:0] step_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t target;
  } ucode_t;

  localparam step_t StepWait = 4'd0;
  localparam step_t StepPred = 4'd1;
  localparam step_t StepSum  = 4'd2;
  localparam step_t StepNum  = 4'd3;
  localparam step_t StepDiv  = 4'd4;
  localparam step_t StepErr  = 4'd5;
  localparam step_t StepMulE = 4'd6;
  localparam step_t StepUpdX = 4'd7;
  localparam step_t StepMulP = 4'd8;
  localparam step_t StepUpdP = 4'd9;
  localparam step_t StepRst  = 4'd10;
  localparam step_t StepEmit = 4'd11;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      StepWait: w = '{op: UOP_LATCH, cond: COND_ACCEPT, target: StepRst};
      StepPred: w = '{op: UOP_PRED,  cond: COND_NEXT,   target: StepWait};
      StepSum:  w = '{op: UOP_SUM,   cond: COND_NEXT,   target: StepWait};
      StepNum:  w = '{op: UOP_NUM,   cond: COND_ZERO,   target: StepErr};
      StepDiv:  w = '{op: UOP_DIV,   cond: COND_LOOP,   target: StepDiv};
      StepErr:  w = '{op: UOP_ERR,   cond: COND_NEXT,   target: StepWait};
      StepMulE: w = '{op: UOP_MULE,  cond: COND_NEXT,   target: StepWait};
      StepUpdX: w = '{op: UOP_UPDX,  cond: COND_NEXT,   target: StepWait};
      StepMulP: w = '{op: UOP_MULP,  cond: COND_NEXT,   target: StepWait};
      StepUpdP: w = '{op: UOP_UPDP,  cond: COND_JUMP,   target: StepEmit};
      StepRst:  w = '{op: UOP_RST,   cond: COND_NEXT,   target: StepWait};
      StepEmit: w = '{op: UOP_EMIT,  cond: COND_EMIT,   target: StepWait};
      default:  w = '{op: UOP_NOP,   cond: COND_JUMP,   target: StepWait};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/skf_in_if.sv @@
// Input channel of the scalar Kalman filter: command word with measurement and its noise.
interface skf_in_if import skf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic signed [EstW-1:0] measurement;
  logic [CovW-1:0]        measurement_noise;

  modport source (output valid, command, measurement, measurement_noise, input ready);
  modport sink (input valid, command, measurement, measurement_noise, output ready);
endinterface

@@ rtl/skf_out_if.sv @@
// Result channel of the scalar Kalman filter: estimate, gain and error covariance.
interface skf_out_if import skf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [EstW-1:0] estimate;
  logic [GainW-1:0]       gain;
  logic [CovW-1:0]        error_cov;

  modport source (output valid, estimate, gain, error_cov, input ready);
  modport sink (input valid, estimate, gain, error_cov, output ready);
endinterface

@@ rtl/scalar_kalman_filter_core.sv @@
// Scalar Kalman filter core: microcoded sequencer over a shared divider/multiplier datapath.
//
// One word at a time. A restart word reloads estimate and covariance from the
// configuration registers. An update word runs predict, gain, estimate and
// covariance steps. The restoring divider forms the gain one quotient bit per
// cycle, and the shared 18x33 multiplier forms both products. When P + R is
// zero the divider is skipped. The sequencer is back at its wait step as the
// result loads, so the next word is accepted in the following cycle at the
// earliest. A finished result sits in the output register, and the next word
// is taken while it waits. A second finished word holds at the emit step until
// the receiver frees the register. Configuration writes to the initial estimate
// and covariance take effect at the next restart; process noise writes take
// effect at the next predict step.
module scalar_kalman_filter_core import skf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  skf_in_if.sink              in_i,
  skf_out_if.source           out_o
);

  // configuration and filter state
  logic [EstW-1:0]        init_est_q, init_est_d;
  logic [CovW-1:0]        init_cov_q, init_cov_d;
  logic [CovW-1:0]        proc_noise_q, proc_noise_d;
  logic signed [EstW-1:0] estimate_q, estimate_d;
  logic [CovW-1:0]        cov_q, cov_d;

  // sequencer
  step_t                  pc_q, pc_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  ucode_t                 ctrl;
  logic                   in_fire;
  logic                   out_free;

  // scratch datapath
  logic signed [EstW-1:0] z_q;
  logic [CovW-1:0]        r_q;
  logic [CovW-1:0]        p_q;
  logic [DivW-1:0]        div_q;
  logic [DivW-1:0]        rem_q;
  logic [GainBits:0]      nlow_q;
  logic [GainW-1:0]       gain_q;
  logic signed [EstW:0]   err_q;
  logic signed [MulW-1:0] mul_q;

  // output register
  logic signed [EstW-1:0] out_est_q;
  logic [GainW-1:0]       out_gain_q;
  logic [CovW-1:0]        out_cov_q;

  // combinational datapath
  logic [DivW-1:0]        pred_sum;
  logic [CovW-1:0]        pred_sat;
  logic [NumW-1:0]        num;
  logic [DivW:0]          trial;
  logic [DivW:0]          trial_diff;
  logic                   trial_ge;
  logic signed [GainW:0]  mul_a;
  logic signed [EstW:0]   mul_b;
  logic signed [MulW-1:0] mul_p;
  logic signed [MulW-1:0] rnd_sum;
  logic signed [EstW+2:0] rnd_shift;
  logic signed [EstW+3:0] nx;
  logic signed [EstW-1:0] nx_sat;

  assign ctrl     = ucode_rom(pc_q);
  assign in_fire  = in_i.valid && (ctrl.cond == COND_ACCEPT);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready      = (ctrl.cond == COND_ACCEPT);
  assign out_o.valid     = out_valid_q;
  assign out_o.estimate  = out_est_q;
  assign out_o.gain      = out_gain_q;
  assign out_o.error_cov = out_cov_q;

  // predict: saturate P + Q to the covariance range
  assign pred_sum = {1'b0, cov_q} + {1'b0, proc_noise_q};
  assign pred_sat = pred_sum[DivW-1] ? CovMax : pred_sum[CovW-1:0];

  // gain numerator (P << 16) + sum/2; its top bits already sit below the divisor
  assign num = {1'b0, p_q, {GainBits{1'b0}}} + {{(NumW-CovW){1'b0}}, div_q[DivW-1:1]};

  assign trial      = {rem_q, nlow_q[GainBits]};
  assign trial_ge   = trial >= {1'b0, div_q};
  assign trial_diff = trial - {1'b0, div_q};

  // shared multiplier: gain * error, or (one - gain) * P
  always_comb begin
    if (ctrl.op == UOP_MULE) begin
      mul_a = $signed({1'b0, gain_q});
      mul_b = err_q;
    end else begin
      mul_a = $signed({1'b0, GainOne - gain_q});
      mul_b = $signed({2'b00, p_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  // round half up, then drop the gain fraction
  assign rnd_sum   = mul_q + RoundHalf;
  assign rnd_shift = rnd_sum[GainBits +: (EstW+3)];
  assign nx        = $signed({{4{estimate_q[EstW-1]}}, estimate_q})
                   + $signed({rnd_shift[EstW+2], rnd_shift});

  always_comb begin
    if (nx[EstW+3:EstW-1] == '0 || nx[EstW+3:EstW-1] == '1) begin
      nx_sat = nx[EstW-1:0];
    end else if (nx[EstW+3]) begin
      nx_sat = {1'b1, {(EstW-1){1'b0}}};
    end else begin
      nx_sat = {1'b0, {(EstW-1){1'b1}}};
    end
  end

  // configuration writes
  always_comb begin
    init_est_d   = init_est_q;
    init_cov_d   = init_cov_q;
    proc_noise_d = proc_noise_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INIT_EST:   init_est_d   = cfg_wdata_i[EstW-1:0];
        CFG_INIT_COV:   init_cov_d   = cfg_wdata_i[CovW-1:0];
        CFG_PROC_NOISE: proc_noise_d = cfg_wdata_i[CovW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next step and state updates
  always_comb begin
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    estimate_d  = estimate_q;
    cov_d       = cov_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (ctrl.cond)
      COND_NEXT:   pc_d = pc_q + step_t'(1);
      COND_JUMP:   pc_d = ctrl.target;
      COND_ZERO:   pc_d = (div_q == '0) ? ctrl.target : pc_q + step_t'(1);
      COND_LOOP:   pc_d = (cnt_q != '0) ? ctrl.target : pc_q + step_t'(1);
      COND_ACCEPT: begin
        if (in_fire) begin
          pc_d = in_i.command ? pc_q + step_t'(1) : ctrl.target;
        end
      end
      COND_EMIT:   pc_d = out_free ? ctrl.target : pc_q;
      default:     pc_d = StepWait;
    endcase

    case (ctrl.op)
      UOP_NUM:  cnt_d = DivLastBit;
      UOP_DIV:  cnt_d = cnt_q - CntW'(1);
      UOP_UPDX: estimate_d = nx_sat;
      UOP_UPDP: cov_d = rnd_sum[GainBits +: CovW];
      UOP_RST: begin
        estimate_d = init_est_q;
        cov_d      = init_cov_q;
      end
      UOP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_est_q   <= InitEstReset;
      init_cov_q   <= InitCovReset;
      proc_noise_q <= ProcNoiseReset;
      estimate_q   <= InitEstReset;
      cov_q        <= InitCovReset;
      pc_q         <= StepWait;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      init_est_q   <= init_est_d;
      init_cov_q   <= init_cov_d;
      proc_noise_q <= proc_noise_d;
      estimate_q   <= estimate_d;
      cov_q        <= cov_d;
      pc_q         <= pc_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // scratch and output registers
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      UOP_LATCH: begin
        if (in_fire) begin
          z_q <= in_i.measurement;
          r_q <= in_i.measurement_noise;
        end
      end
      UOP_PRED: p_q <= pred_sat;
      UOP_SUM:  div_q <= {1'b0, p_q} + {1'b0, r_q};
      UOP_NUM: begin
        rem_q  <= {1'b0, num[NumW-1:GainBits+1]};
        nlow_q <= num[GainBits:0];
        gain_q <= '0;
      end
      UOP_DIV: begin
        // one quotient bit per step, restoring
        rem_q  <= trial_ge ? trial_diff[DivW-1:0] : trial[DivW-1:0];
        nlow_q <= {nlow_q[GainBits-1:0], 1'b0};
        gain_q <= {gain_q[GainW-2:0], trial_ge};
      end
      UOP_ERR:  err_q <= $signed({z_q[EstW-1], z_q}) - $signed({estimate_q[EstW-1], estimate_q});
      UOP_MULE: mul_q <= mul_p;
      UOP_MULP: mul_q <= mul_p;
      UOP_RST:  gain_q <= '0;
      UOP_EMIT: begin
        if (out_free) begin
          out_est_q  <= estimate_q;
          out_gain_q <= gain_q;
          out_cov_q  <= cov_q;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the scalar Kalman filter core: directed table, then randomized phases.
module tb;
  import skf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam time ClkHalf = 4ns;

  localparam logic CmdRestart = 1'b0;
  localparam logic CmdUpdate  = 1'b1;

  // index past the last register; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  localparam longint GainUnit = longint'(GainOne);
  localparam longint GainHalf = GainUnit / 2;
  localparam longint CovLimit = longint'(CovMax);
  localparam longint EstHigh  = 64'sd2147483647;
  localparam longint EstLow   = -64'sd2147483648;

  localparam int unsigned WordsPerPhase = 260;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 40;

  typedef struct packed {
    logic signed [EstW-1:0] est;
    logic [GainW-1:0]       gain;
    logic [CovW-1:0]        cov;
  } filt_out_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [CfgIdxW-1:0]     idx;
    logic [CfgDataW-1:0]    wdata;
    logic                   cmd;
    logic signed [EstW-1:0] z;
    logic [CovW-1:0]        r;
    logic                   known;
    filt_out_t              want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                rx_hold = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned mismatch_count = 0;

  // filter state and register shadow
  logic signed [EstW-1:0] kf_est;
  logic [CovW-1:0]        kf_cov;
  logic signed [EstW-1:0] init_est_q;
  logic [CovW-1:0]        init_cov_q;
  logic [CovW-1:0]        proc_noise_q;

  filt_out_t pending_results[$];

  skf_in_if  in_if ();
  skf_out_if out_if ();

  scalar_kalman_filter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic filt_out_t kalman_step(logic cmd, logic signed [EstW-1:0] z,
                                            logic [CovW-1:0] r);
    filt_out_t res;
    longint    p;
    longint    sum;
    longint    g;
    longint    err;
    longint    nx;
    g = 0;
    if (cmd == CmdRestart) begin
      kf_est = init_est_q;
      kf_cov = init_cov_q;
    end else begin
      p = longint'(kf_cov) + longint'(proc_noise_q);
      if (p > CovLimit) p = CovLimit;
      sum = p + longint'(r);
      if (sum != 0) g = ((p << GainBits) + (sum >> 1)) / sum;
      if (g > GainUnit) g = GainUnit;
      err = longint'(z) - longint'(kf_est);
      // floor(g*err/2^16 + 1/2): arithmetic shift floors negatives
      nx = longint'(kf_est) + ((g * err + GainHalf) >>> GainBits);
      if (nx > EstHigh) nx = EstHigh;
      if (nx < EstLow) nx = EstLow;
      kf_est = EstW'(nx);
      p = ((GainUnit - g) * p + GainHalf) >> GainBits;
      if (p > CovLimit) p = CovLimit;
      kf_cov = CovW'(p);
    end
    res.est  = kf_est;
    res.gain = GainW'(g);
    res.cov  = kf_cov;
    return res;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] wdata);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = wdata;
    return row;
  endfunction

  function automatic stim_row_t word_row(logic cmd, logic signed [EstW-1:0] z,
                                         logic [CovW-1:0] r);
    stim_row_t row;
    row     = '0;
    row.cmd = cmd;
    row.z   = z;
    row.r   = r;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic cmd, logic signed [EstW-1:0] z,
                                          logic [CovW-1:0] r, logic signed [EstW-1:0] est,
                                          logic [GainW-1:0] gain, logic [CovW-1:0] cov);
    stim_row_t row;
    row           = word_row(cmd, z, r);
    row.known     = 1'b1;
    row.want.est  = est;
    row.want.gain = gain;
    row.want.cov  = cov;
    return row;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // result side: compare every accepted word against the oldest prediction
  always @(posedge clk_i) begin
    filt_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, estimate", 0, longint'(out_if.estimate));
      end else begin
        want = pending_results.pop_front();
        if (out_if.estimate !== want.est)
          report_mismatch("estimate", longint'(want.est), longint'(out_if.estimate));
        if (out_if.gain !== want.gain)
          report_mismatch("gain", longint'(want.gain), longint'(out_if.gain));
        if (out_if.error_cov !== want.cov)
          report_mismatch("error_cov", longint'(want.cov), longint'(out_if.error_cov));
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= rst_ni && !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic hold_receiver(int unsigned cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] wdata);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= wdata;
    case (idx)
      CFG_INIT_EST:   init_est_q   = wdata;
      CFG_INIT_COV:   init_cov_q   = wdata[CovW-1:0];
      CFG_PROC_NOISE: proc_noise_q = wdata[CovW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold valid low until every predicted word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_word(logic cmd, logic signed [EstW-1:0] z, logic [CovW-1:0] r,
                           logic known, filt_out_t want);
    filt_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.command           <= cmd;
    in_if.measurement       <= z;
    in_if.measurement_noise <= r;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = kalman_step(cmd, z, r);
    pending_results.push_back(known ? want : res);
  endtask

  task automatic send_random_word();
    logic                   cmd;
    logic signed [EstW-1:0] z;
    logic [CovW-1:0]        r;
    int unsigned            pick;
    cmd = ($urandom_range(99) < 8) ? CmdRestart : CmdUpdate;
    // half the measurements land near the estimate so gains stay meaningful
    if ($urandom_range(1)) z = $urandom;
    else z = kf_est + ($urandom & 32'h0003_FFFF) - 32'h0002_0000;
    pick = $urandom_range(99);
    if (pick < 5) r = '0;
    else if (pick < 10) r = CovMax;
    else if (pick < 30) r = CovW'($urandom);
    else r = CovW'($urandom_range(0, 1 << 20));
    send_word(cmd, z, r, 1'b0, '0);
  endtask

  task automatic randomize_regs();
    logic [CfgDataW-1:0] wdata;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 12) wdata = 32'h8000_0000;
    else if (pick < 25) wdata = 32'h7FFF_FFFF;
    else wdata = $urandom;
    write_reg(CFG_INIT_EST, wdata);
    pick = $urandom_range(99);
    if (pick < 12) wdata = '0;
    else if (pick < 25) wdata = {1'b0, CovMax};
    else wdata = $urandom_range(0, 1 << 24);
    wdata[CfgDataW-1] = 1'($urandom_range(1));
    write_reg(CFG_INIT_COV, wdata);
    pick = $urandom_range(99);
    if (pick < 20) wdata = '0;
    else if (pick < 30) wdata = $urandom | 32'h7FFF_FFFF;
    else wdata = $urandom_range(0, 1 << 16);
    write_reg(CFG_PROC_NOISE, wdata);
    if ($urandom_range(1)) write_reg(CfgIdxSpare, $urandom);
  endtask

  initial begin
    stim_row_t dir_rows[$];
    int unsigned idle_plan[5];
    int unsigned stall_plan[5];

    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= '0;
    cfg_wdata_i             <= '0;
    in_if.valid             <= 1'b0;
    in_if.command           <= CmdRestart;
    in_if.measurement       <= '0;
    in_if.measurement_noise <= '0;

    init_est_q   = InitEstReset;
    init_cov_q   = InitCovReset;
    proc_noise_q = ProcNoiseReset;
    kf_est       = InitEstReset;
    kf_cov       = InitCovReset;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, then zero noise driving the gain to one
    dir_rows.push_back(known_row(CmdRestart, 0, 0, 32'sd3276800, 0, 31'd65536));
    dir_rows.push_back(known_row(CmdUpdate, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, GainOne, 0));
    dir_rows.push_back(known_row(CmdUpdate, 32'h8000_0000, 0, 32'h8000_0000, GainOne, 0));
    dir_rows.push_back(word_row(CmdUpdate, 32'h7FFF_FFFF, CovMax));
    // no process noise: zero covariance plus zero noise gives zero gain
    dir_rows.push_back(cfg_row(CFG_PROC_NOISE, 32'h0));
    dir_rows.push_back(known_row(CmdRestart, 0, 0, 32'sd3276800, 0, 31'd65536));
    dir_rows.push_back(known_row(CmdUpdate, 32'sd1234, 0, 32'sd1234, GainOne, 0));
    dir_rows.push_back(known_row(CmdUpdate, 32'h7FFF_FFFF, 0, 32'sd1234, 0, 0));
    dir_rows.push_back(known_row(CmdUpdate, -32'sd5, CovMax, 32'sd1234, 0, 0));
    // extremes, with the bit above the covariance width set
    dir_rows.push_back(cfg_row(CFG_INIT_EST, 32'h8000_0000));
    dir_rows.push_back(cfg_row(CFG_INIT_COV, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_PROC_NOISE, 32'hFFFF_FFFF));
    dir_rows.push_back(known_row(CmdRestart, 0, 0, 32'h8000_0000, 0, CovMax));
    dir_rows.push_back(known_row(CmdUpdate, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, GainOne, 0));
    dir_rows.push_back(word_row(CmdUpdate, 32'h8000_0000, CovMax));
    // new start values stay parked until the next restart; spare index is dropped
    dir_rows.push_back(cfg_row(CfgIdxSpare, 32'h1234_5678));
    dir_rows.push_back(cfg_row(CFG_INIT_EST, 32'h7FFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_INIT_COV, 32'h0));
    dir_rows.push_back(word_row(CmdUpdate, 32'sd100, 31'd100));
    dir_rows.push_back(known_row(CmdRestart, 0, 0, 32'h7FFF_FFFF, 0, 0));
    dir_rows.push_back(word_row(CmdUpdate, 32'h8000_0000, 31'd1));
    dir_rows.push_back(cfg_row(CFG_PROC_NOISE, 32'd3277));
    dir_rows.push_back(cfg_row(CFG_INIT_EST, 32'd3276800));
    dir_rows.push_back(cfg_row(CFG_INIT_COV, 32'd65536));
    dir_rows.push_back(known_row(CmdRestart, 0, 0, 32'sd3276800, 0, 31'd65536));
    dir_rows.push_back(word_row(CmdUpdate, 32'hFFFF_0000, 31'd65536));
    dir_rows.push_back(word_row(CmdUpdate, 32'h0, 31'd1));
    dir_rows.push_back(word_row(CmdUpdate, 32'h5555_5555, 31'h2AAA_AAAA));
    dir_rows.push_back(word_row(CmdUpdate, 32'hAAAA_AAAA, 31'h5555_5555));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        send_word(dir_rows[i].cmd, dir_rows[i].z, dir_rows[i].r, dir_rows[i].known,
                  dir_rows[i].want);
      end
    end

    // last phase has a busy sender against a receiver that holds off
    idle_plan  = '{0, 77, 0, 16, 0};
    stall_plan = '{0, 0, 77, 16, 0};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      randomize_regs();
      send_idle_pct = idle_plan[ph];
      stall_pct     = stall_plan[ph];
      if (ph == 4) begin
        fork
          hold_receiver(HoldCycles);
        join_none
      end
      repeat (WordsPerPhase) send_random_word();
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
